>>> design/crs_pkg.sv
// Shared types and constants for the Catmull-Rom spline evaluator.
// Used by crs_point_ram and catmull_rom_spline_eval; depends on nothing.
package crs_pkg;

  localparam int MAX_POINTS = 16;
  localparam int PT_IDX_W   = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int NUM_AXES   = 3;
  localparam int NUM_TAPS   = 4;
  localparam int COORD_W    = 32;
  localparam int ALPHA_W    = 17;
  localparam int FRAC_W     = 16;
  localparam int CFG_W      = 5;
  localparam int IDX_IN_W   = 4;
  localparam int SEG_W      = ALPHA_W + CFG_W;
  localparam int SEG_INT_W  = SEG_W - FRAC_W;
  localparam int B_W        = COORD_W + 1;
  localparam int C_W        = COORD_W + 4;
  localparam int D_W        = COORD_W + 3;
  localparam int BT_W       = B_W + ALPHA_W + 1;
  localparam int CT_W       = C_W + ALPHA_W + 1;
  localparam int DT_W       = D_W + ALPHA_W + 1;
  localparam int ACC_W      = 54;
  localparam int OUT_SHIFT  = FRAC_W + 1;
  localparam int MIN_POINTS = 4;

  localparam logic [ALPHA_W-1:0] ONE_Q16 = ALPHA_W'(1) << FRAC_W;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_EVAL  = 1'b1
  } crs_cmd_e;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef coord_t [NUM_AXES-1:0] point_t;

  typedef struct packed {
    crs_cmd_e              command;
    logic [IDX_IN_W-1:0]   point_index;
    logic signed [31:0]    x_in;
    logic signed [31:0]    y_in;
    logic signed [31:0]    z_in;
    logic [ALPHA_W-1:0]    alpha;
  } crs_req_t;

  typedef struct packed {
    logic signed [31:0] x_out;
    logic signed [31:0] y_out;
    logic signed [31:0] z_out;
  } crs_res_t;

endpackage

>>> design/catmull_rom_spline_eval.sv
// Top level of the uniform Catmull-Rom spline evaluator.
// Depends on crs_pkg and four crs_point_ram copies of the point store.
//
// Usage: a request is taken at a rising edge with start high and busy low.
// busy is never raised, so one request may enter in every cycle. A write
// request (command CMD_WRITE) stores x_in, y_in, z_in at point_index and
// gives no result. An evaluate request (CMD_EVAL) gives exactly one result
// on res_o, marked by res_valid_o for one cycle; results leave in request
// order. From the accepting edge, a result passes the point store's
// registered read, a register after each multiply of the chain t*t, t^2*t,
// then d*t^3, and the saturating output register. Throughput is one
// request per cycle; the four store copies give the four curve taps from one
// registered read. A write is visible to every evaluate request taken after it.
// num_points is written through cfg_valid_i/cfg_ready_o/cfg_data_i, ready
// always high, and must only change while no evaluation is in flight.
// Reset clears num_points and the pipeline valid bits; the point store is
// not cleared and must be written before it is read. The receiver cannot
// stall, so no back-pressure exists anywhere in the pipe.
module catmull_rom_spline_eval (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  crs_pkg::crs_req_t  req_i,
  output logic               res_valid_o,
  output crs_pkg::crs_res_t  res_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [crs_pkg::CFG_W-1:0] cfg_data_i
);
  import crs_pkg::*;

  assign busy        = 1'b0;
  assign cfg_ready_o = 1'b1;

  logic [CFG_W-1:0] num_points_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q <= '0;
    end else if (cfg_valid_i && cfg_ready_o) begin
      num_points_q <= cfg_data_i;
    end
  end

  // ---------------------------------------------------------------- stage 1
  logic     s1_valid_q;
  crs_req_t s1_req_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_req_q <= req_i;
  end

  logic [CFG_W-1:0]     n, nm1, nm2;
  logic                 s1_few;
  logic [ALPHA_W-1:0]   alpha_sat;
  logic [SEG_W-1:0]     seg, t_full;
  logic [SEG_INT_W-1:0] seg_int, seg_i, i_prev, i_next, i_next2, i_last, i_end;
  logic [ALPHA_W-1:0]   s1_t;
  logic [PT_IDX_W-1:0]  raddr [NUM_TAPS];
  logic                 ram_we;
  point_t               ram_wdata;
  point_t               ram_rdata [NUM_TAPS];

  always_comb begin
    n = (int'(num_points_q) > MAX_POINTS) ? CFG_W'(MAX_POINTS) : num_points_q;
    s1_few    = int'(n) < MIN_POINTS;
    nm1       = n - CFG_W'(1);
    nm2       = n - CFG_W'(2);
    alpha_sat = (s1_req_q.alpha > ONE_Q16) ? ONE_Q16 : s1_req_q.alpha;
    seg       = SEG_W'(alpha_sat) * SEG_W'(nm1);
    seg_int   = seg[SEG_W-1:FRAC_W];
    // The last segment also takes alpha = 1.0, where t reaches one.
    seg_i     = (seg_int > SEG_INT_W'(nm2)) ? SEG_INT_W'(nm2) : seg_int;
    t_full    = seg - {seg_i, {FRAC_W{1'b0}}};
    s1_t      = t_full[ALPHA_W-1:0];
    i_prev    = (seg_i == '0) ? '0 : seg_i - SEG_INT_W'(1);
    i_next    = seg_i + SEG_INT_W'(1);
    i_next2   = seg_i + SEG_INT_W'(2);
    i_last    = SEG_INT_W'(nm1);
    i_end     = (i_next2 > i_last) ? i_last : i_next2;
    raddr[0]  = PT_IDX_W'(i_prev);
    raddr[1]  = PT_IDX_W'(seg_i);
    raddr[2]  = PT_IDX_W'(i_next);
    raddr[3]  = PT_IDX_W'(i_end);
  end

  always_comb begin
    ram_we = s1_valid_q && (s1_req_q.command == CMD_WRITE) &&
             (int'(s1_req_q.point_index) < MAX_POINTS);
    ram_wdata[0] = s1_req_q.x_in;
    ram_wdata[1] = s1_req_q.y_in;
    ram_wdata[2] = s1_req_q.z_in;
  end

  for (genvar g = 0; g < NUM_TAPS; g++) begin : g_tap
    crs_point_ram u_ram (
      .clk_i   (clk_i),
      .we_i    (ram_we),
      .waddr_i (PT_IDX_W'(s1_req_q.point_index)),
      .wdata_i (ram_wdata),
      .raddr_i (raddr[g]),
      .rdata_o (ram_rdata[g])
    );
  end

  // ---------------------------------------------------------------- stage 2
  logic               s2_valid_q, s2_few_q;
  logic [ALPHA_W-1:0] s2_t_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
    end else begin
      s2_valid_q <= s1_valid_q && (s1_req_q.command == CMD_EVAL);
    end
  end

  always_ff @(posedge clk_i) begin
    s2_few_q <= s1_few;
    s2_t_q   <= s1_t;
  end

  logic [2*ALPHA_W-1:0] tt_prod;
  logic [ALPHA_W-1:0]   s2_t2;
  logic signed [B_W-1:0] s2_b [NUM_AXES];
  logic signed [C_W-1:0] s2_c [NUM_AXES];
  logic signed [D_W-1:0] s2_d [NUM_AXES];

  always_comb begin
    tt_prod = s2_t_q * s2_t_q;
    s2_t2   = tt_prod[FRAC_W+ALPHA_W-1:FRAC_W];
    for (int a = 0; a < NUM_AXES; a++) begin
      s2_b[a] = B_W'($signed(ram_rdata[2][a])) - B_W'($signed(ram_rdata[0][a]));
      s2_c[a] = (C_W'($signed(ram_rdata[0][a])) <<< 1)
              - C_W'($signed(ram_rdata[1][a])) * C_W'(5)
              + (C_W'($signed(ram_rdata[2][a])) <<< 2)
              - C_W'($signed(ram_rdata[3][a]));
      s2_d[a] = D_W'($signed(ram_rdata[1][a])) * D_W'(3)
              - D_W'($signed(ram_rdata[0][a]))
              - D_W'($signed(ram_rdata[2][a])) * D_W'(3)
              + D_W'($signed(ram_rdata[3][a]));
    end
  end

  // ---------------------------------------------------------------- stage 3
  logic                  s3_valid_q, s3_few_q;
  logic [ALPHA_W-1:0]    s3_t_q, s3_t2_q;
  coord_t                s3_p1_q [NUM_AXES];
  logic signed [B_W-1:0] s3_b_q [NUM_AXES];
  logic signed [C_W-1:0] s3_c_q [NUM_AXES];
  logic signed [D_W-1:0] s3_d_q [NUM_AXES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_valid_q <= 1'b0;
    end else begin
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s3_few_q <= s2_few_q;
    s3_t_q   <= s2_t_q;
    s3_t2_q  <= s2_t2;
    for (int a = 0; a < NUM_AXES; a++) begin
      s3_p1_q[a] <= ram_rdata[1][a];
      s3_b_q[a]  <= s2_b[a];
      s3_c_q[a]  <= s2_c[a];
      s3_d_q[a]  <= s2_d[a];
    end
  end

  logic [2*ALPHA_W-1:0]   t3_prod;
  logic [ALPHA_W-1:0]     s3_t3;
  logic signed [ALPHA_W:0] s3_ts, s3_t2s;
  logic signed [BT_W-1:0] s3_bt [NUM_AXES];
  logic signed [CT_W-1:0] s3_ct [NUM_AXES];

  always_comb begin
    t3_prod = s3_t2_q * s3_t_q;
    s3_t3   = t3_prod[FRAC_W+ALPHA_W-1:FRAC_W];
    s3_ts   = $signed({1'b0, s3_t_q});
    s3_t2s  = $signed({1'b0, s3_t2_q});
    for (int a = 0; a < NUM_AXES; a++) begin
      s3_bt[a] = s3_b_q[a] * s3_ts;
      s3_ct[a] = s3_c_q[a] * s3_t2s;
    end
  end

  // ---------------------------------------------------------------- stage 4
  logic                   s4_valid_q, s4_few_q;
  logic [ALPHA_W-1:0]     s4_t3_q;
  coord_t                 s4_p1_q [NUM_AXES];
  logic signed [D_W-1:0]  s4_d_q  [NUM_AXES];
  logic signed [BT_W-1:0] s4_bt_q [NUM_AXES];
  logic signed [CT_W-1:0] s4_ct_q [NUM_AXES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_few_q <= s3_few_q;
    s4_t3_q  <= s3_t3;
    for (int a = 0; a < NUM_AXES; a++) begin
      s4_p1_q[a] <= s3_p1_q[a];
      s4_d_q[a]  <= s3_d_q[a];
      s4_bt_q[a] <= s3_bt[a];
      s4_ct_q[a] <= s3_ct[a];
    end
  end

  logic signed [ALPHA_W:0] s4_t3s;
  logic signed [DT_W-1:0]  s4_dt  [NUM_AXES];
  logic signed [ACC_W-1:0] s4_sum [NUM_AXES];

  always_comb begin
    s4_t3s = $signed({1'b0, s4_t3_q});
    for (int a = 0; a < NUM_AXES; a++) begin
      s4_dt[a]  = s4_d_q[a] * s4_t3s;
      s4_sum[a] = (ACC_W'(s4_p1_q[a]) <<< OUT_SHIFT) + ACC_W'(s4_bt_q[a])
                + ACC_W'(s4_ct_q[a]);
    end
  end

  // ---------------------------------------------------------------- stage 5
  logic                    s5_valid_q, s5_few_q;
  logic signed [DT_W-1:0]  s5_dt_q  [NUM_AXES];
  logic signed [ACC_W-1:0] s5_sum_q [NUM_AXES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_valid_q <= 1'b0;
    end else begin
      s5_valid_q <= s4_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s5_few_q <= s4_few_q;
    for (int a = 0; a < NUM_AXES; a++) begin
      s5_dt_q[a]  <= s4_dt[a];
      s5_sum_q[a] <= s4_sum[a];
    end
  end

  logic signed [ACC_W-1:0] s5_acc [NUM_AXES];
  logic signed [ACC_W-1:0] s5_shr [NUM_AXES];
  coord_t                  s5_out [NUM_AXES];

  always_comb begin
    for (int a = 0; a < NUM_AXES; a++) begin
      s5_acc[a] = s5_sum_q[a] + ACC_W'(s5_dt_q[a]);
      s5_shr[a] = s5_acc[a] >>> OUT_SHIFT;
      // In range when every bit above the coordinate's sign bit matches it.
      if (s5_shr[a][ACC_W-1:COORD_W-1] == '0 || s5_shr[a][ACC_W-1:COORD_W-1] == '1) begin
        s5_out[a] = s5_shr[a][COORD_W-1:0];
      end else if (s5_shr[a][ACC_W-1]) begin
        s5_out[a] = {1'b1, {(COORD_W-1){1'b0}}};
      end else begin
        s5_out[a] = {1'b0, {(COORD_W-1){1'b1}}};
      end
      if (s5_few_q) begin
        s5_out[a] = '0;
      end
    end
  end

  // ------------------------------------------------------------ output reg
  logic     res_valid_q;
  crs_res_t res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= s5_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q.x_out <= s5_out[0];
    res_q.y_out <= s5_out[1];
    res_q.z_out <= s5_out[2];
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

>>> design/crs_point_ram.sv
// Control point store: one write port, one registered read port.
// Depends on crs_pkg for the point type and depth.
module crs_point_ram (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [crs_pkg::PT_IDX_W-1:0] waddr_i,
  input  crs_pkg::point_t          wdata_i,
  input  logic [crs_pkg::PT_IDX_W-1:0] raddr_i,
  output crs_pkg::point_t          rdata_o
);
  import crs_pkg::*;

  point_t mem_q [MAX_POINTS];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> tb/sv/catmull_rom_spline_eval_tb.sv
// Self-checking testbench for catmull_rom_spline_eval: point writes and curve
// evaluations against an in-bench Catmull-Rom predictor, with random gaps.
// Depends on crs_pkg and the catmull_rom_spline_eval RTL.
module catmull_rom_spline_eval_tb;
  import crs_pkg::*;

  localparam int          PIPE_LAT    = 5;
  localparam int          RAND_ITEMS  = 700;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam longint      SAT_HI      = 64'sd2147483647;
  localparam longint      SAT_LO      = -64'sd2147483648;

  typedef enum logic {ROW_REQ, ROW_CFG} row_kind_e;

  typedef struct {
    row_kind_e        kind;
    crs_req_t         req;
    logic [CFG_W-1:0] cfg_value;
    bit               known;
    crs_res_t         known_res;
  } stim_row_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             start       = 1'b0;
  logic             busy;
  crs_req_t         req_i       = '0;
  logic             res_valid_o;
  crs_res_t         res_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [CFG_W-1:0] cfg_data_i  = '0;

  // Predictor state: the point store, which slots hold data, and num_points.
  coord_t           pts_x [MAX_POINTS];
  coord_t           pts_y [MAX_POINTS];
  coord_t           pts_z [MAX_POINTS];
  logic [15:0]      pts_loaded = '0;
  logic [CFG_W-1:0] curve_len  = '0;

  crs_res_t    spline_q [$];
  stim_row_t   dir_rows [$];
  int          error_count     = 0;
  int          results_checked = 0;
  int          writes_sent     = 0;
  int          evals_sent      = 0;
  int          settings_count  = 0;
  int unsigned cycle_count     = 0;

  catmull_rom_spline_eval uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .req_i      (req_i),
    .res_valid_o(res_valid_o),
    .res_o      (res_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_data_i (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  task automatic flag_error(string msg);
    $display("ERROR @%0d cycles: %s", cycle_count, msg);
    error_count++;
  endtask

  function automatic coord_t blend_axis(coord_t p0, coord_t p1, coord_t p2, coord_t p3,
                                        longint t, longint t2, longint t3);
    longint b, c, d, acc, sh;
    b   = longint'(p2) - longint'(p0);
    c   = 2 * longint'(p0) - 5 * longint'(p1) + 4 * longint'(p2) - longint'(p3);
    d   = -longint'(p0) + 3 * longint'(p1) - 3 * longint'(p2) + longint'(p3);
    acc = 2 * longint'(p1) * 65536 + b * t + c * t2 + d * t3;
    sh  = acc >>> OUT_SHIFT;
    if (sh > SAT_HI) return 32'sh7FFF_FFFF;
    if (sh < SAT_LO) return 32'sh8000_0000;
    return coord_t'(sh);
  endfunction

  function automatic crs_res_t spline_point(logic [ALPHA_W-1:0] alpha);
    int unsigned n, a, seg, i, i0, i3;
    longint      t, t2, t3;
    crs_res_t    r;
    r = '0;
    n = (curve_len > MAX_POINTS) ? MAX_POINTS : curve_len;
    if (n < MIN_POINTS) return r;
    a   = (alpha > ONE_Q16) ? ONE_Q16 : alpha;
    seg = a * (n - 1);
    i   = seg >> FRAC_W;
    if (i > n - 2) i = n - 2;
    t  = longint'(seg - (i << FRAC_W));
    t2 = (t * t) >>> FRAC_W;
    t3 = (t2 * t) >>> FRAC_W;
    i0 = (i == 0) ? 0 : i - 1;
    i3 = (i + 2 > n - 1) ? n - 1 : i + 2;
    r.x_out = blend_axis(pts_x[i0], pts_x[i], pts_x[i+1], pts_x[i3], t, t2, t3);
    r.y_out = blend_axis(pts_y[i0], pts_y[i], pts_y[i+1], pts_y[i3], t, t2, t3);
    r.z_out = blend_axis(pts_z[i0], pts_z[i], pts_z[i+1], pts_z[i3], t, t2, t3);
    return r;
  endfunction

  function automatic void add_write(int idx, coord_t x, coord_t y, coord_t z);
    stim_row_t row;
    row = '{kind: ROW_REQ, req: '0, cfg_value: '0, known: 1'b0, known_res: '0};
    row.req.command     = CMD_WRITE;
    row.req.point_index = IDX_IN_W'(idx);
    row.req.x_in        = x;
    row.req.y_in        = y;
    row.req.z_in        = z;
    dir_rows.push_back(row);
  endfunction

  function automatic void add_eval(int alpha, bit known, coord_t x, coord_t y, coord_t z);
    stim_row_t row;
    row = '{kind: ROW_REQ, req: '0, cfg_value: '0, known: known, known_res: '0};
    row.req.command   = CMD_EVAL;
    row.req.alpha     = ALPHA_W'(alpha);
    row.known_res     = '{x_out: x, y_out: y, z_out: z};
    dir_rows.push_back(row);
  endfunction

  function automatic void add_cfg(int n);
    dir_rows.push_back('{kind: ROW_CFG, req: '0, cfg_value: CFG_W'(n), known: 1'b0,
                         known_res: '0});
  endfunction

  // Leaves start high; the caller lowers it only when a gap follows.
  task automatic send_req(crs_req_t r, bit known, crs_res_t known_res);
    start <= 1'b1;
    req_i <= r;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    if (r.command == CMD_WRITE) begin
      if (r.point_index < MAX_POINTS) begin
        pts_x[r.point_index]      = r.x_in;
        pts_y[r.point_index]      = r.y_in;
        pts_z[r.point_index]      = r.z_in;
        pts_loaded[r.point_index] = 1'b1;
      end
      writes_sent++;
    end else begin
      spline_q.push_back(known ? known_res : spline_point(r.alpha));
      evals_sent++;
    end
  endtask

  task automatic idle_gap(bit no_gaps);
    int roll, g;
    roll = $urandom_range(0, 99);
    if (no_gaps || roll < 60) g = 0;
    else if (roll < 90)       g = $urandom_range(1, 3);
    else if (roll < 98)       g = $urandom_range(4, 12);
    else                      g = $urandom_range(20, 60);
    if (g > 0) begin
      start <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  // Write requests give no result, so extra waiting after the last result lets them settle too.
  task automatic wait_pipe_empty();
    start <= 1'b0;
    while (spline_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 3) @(posedge clk_i);
  endtask

  task automatic write_num_points(logic [CFG_W-1:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
    curve_len = v;
    settings_count++;
  endtask

  function automatic coord_t rand_coord();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 25) return coord_t'($urandom);
    if (roll < 70) return coord_t'(int'($urandom_range(0, 2097151)) - 1048576);
    if (roll < 85) begin
      case ($urandom_range(0, 3))
        0:       return 32'sh7FFF_FFFF;
        1:       return 32'sh8000_0000;
        2:       return 32'sh0000_0000;
        default: return -32'sd1;
      endcase
    end
    if (roll < 92) return 32'sh7FFF_FFFF - coord_t'($urandom_range(0, 255));
    return 32'sh8000_0000 + coord_t'($urandom_range(0, 255));
  endfunction

  function automatic logic [ALPHA_W-1:0] rand_alpha();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 70) return ALPHA_W'($urandom_range(0, 65536));
    if (roll < 80) return ($urandom_range(0, 1) != 0) ? ONE_Q16 : '0;
    return ALPHA_W'($urandom_range(0, 131071));
  endfunction

  // An evaluation may only read slots that hold data, so until the points in
  // use are loaded an evaluate request is turned into a write of a free slot.
  function automatic crs_req_t rand_req();
    crs_req_t    r;
    int unsigned need;
    logic [15:0] need_mask;
    r.point_index = IDX_IN_W'($urandom_range(0, 15));
    r.x_in        = rand_coord();
    r.y_in        = rand_coord();
    r.z_in        = rand_coord();
    r.alpha       = rand_alpha();
    r.command     = ($urandom_range(0, 99) < 60) ? CMD_EVAL : CMD_WRITE;
    need      = (curve_len > MAX_POINTS) ? MAX_POINTS : curve_len;
    need_mask = (need >= 16) ? 16'hFFFF : ((16'd1 << need) - 16'd1);
    if (r.command == CMD_EVAL && need >= MIN_POINTS && (pts_loaded & need_mask) != need_mask)
    begin
      r.command = CMD_WRITE;
      for (int k = 15; k >= 0; k--) begin
        if (need_mask[k] && !pts_loaded[k]) r.point_index = IDX_IN_W'(k);
      end
    end
    return r;
  endfunction

  always @(posedge clk_i) begin : res_check
    crs_res_t want;
    if (rst_ni && res_valid_o) begin
      if (spline_q.size() == 0) begin
        flag_error("result with no evaluate request waiting");
      end else begin
        want = spline_q.pop_front();
        if (res_o.x_out !== want.x_out)
          flag_error($sformatf("x_out got %0d want %0d", res_o.x_out, want.x_out));
        if (res_o.y_out !== want.y_out)
          flag_error($sformatf("y_out got %0d want %0d", res_o.y_out, want.y_out));
        if (res_o.z_out !== want.z_out)
          flag_error($sformatf("z_out got %0d want %0d", res_o.z_out, want.z_out));
        results_checked++;
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Timeout: %0d results still outstanding", spline_q.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  initial begin
    int          rand_sent, phase, phase_items, pause_at;
    bit          no_gaps;
    logic [4:0]  n_pick;

    // Directed part. Rows with a typed result: fewer than four points give
    // zero, alpha zero lands on the first point and alpha at or above one
    // lands on the last point in use.
    add_eval(0, 1'b1, 0, 0, 0);
    add_eval(131071, 1'b1, 0, 0, 0);
    add_write(0, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_1000);
    add_write(1, 32'sh8000_0000, 32'sh7FFF_FFFF, -32'sd4096);
    add_write(2, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh0003_2000);
    add_write(3, 32'sh8000_0000, 32'sh8000_0000, 32'sh0000_0000);
    add_write(15, -32'sd1, 32'sd1, 32'sh5555_5555);
    add_cfg(3);
    add_eval(32768, 1'b1, 0, 0, 0);
    add_cfg(4);
    add_eval(0, 1'b1, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0000_1000);
    add_eval(65536, 1'b1, 32'sh8000_0000, 32'sh8000_0000, 32'sh0000_0000);
    add_eval(131071, 1'b1, 32'sh8000_0000, 32'sh8000_0000, 32'sh0000_0000);
    add_eval(65537, 1'b1, 32'sh8000_0000, 32'sh8000_0000, 32'sh0000_0000);
    add_eval(65535, 1'b0, 0, 0, 0);
    add_eval(21845, 1'b0, 0, 0, 0);
    add_eval(32768, 1'b0, 0, 0, 0);
    add_eval(1, 1'b0, 0, 0, 0);
    add_write(1, 32'sh0000_8000, -32'sh0000_3000, 32'sh0000_0010);
    add_eval(32768, 1'b0, 0, 0, 0);
    add_eval(10000, 1'b0, 0, 0, 0);

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[k]) begin
      if (dir_rows[k].kind == ROW_CFG) begin
        wait_pipe_empty();
        write_num_points(dir_rows[k].cfg_value);
      end else begin
        send_req(dir_rows[k].req, dir_rows[k].known, dir_rows[k].known_res);
        idle_gap(1'b0);
      end
    end

    // Random part: phases of one num_points setting each, the extremes first.
    rand_sent = 0;
    phase     = 0;
    while (rand_sent < RAND_ITEMS) begin
      case (phase)
        0:       n_pick = 5'd16;
        1:       n_pick = 5'd31;
        2:       n_pick = 5'd0;
        3:       n_pick = 5'd4;
        default: begin
          case ($urandom_range(0, 9))
            0:       n_pick = CFG_W'($urandom_range(0, 3));
            1:       n_pick = 5'd16;
            2:       n_pick = CFG_W'($urandom_range(17, 31));
            default: n_pick = CFG_W'($urandom_range(4, 15));
          endcase
        end
      endcase
      wait_pipe_empty();
      write_num_points(n_pick);
      phase_items = $urandom_range(40, 80);
      pause_at    = $urandom_range(0, phase_items - 1);
      no_gaps     = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < phase_items && rand_sent < RAND_ITEMS; k++) begin
        send_req(rand_req(), 1'b0, '0);
        rand_sent++;
        if (k == pause_at) wait_pipe_empty();
        else idle_gap(no_gaps);
      end
      phase++;
    end

    start <= 1'b0;
    while (spline_q.size() != 0) @(posedge clk_i);
    repeat (PIPE_LAT + 5) @(posedge clk_i);

    $display("Covered %0d point writes and %0d evaluations over %0d num_points settings,",
             writes_sent, evals_sent, settings_count);
    $display("with %0d results compared field by field.", results_checked);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
